FILE: rtl/core/prefix_code_bit_packer_defines.svh
`ifndef PREFIX_CODE_BIT_PACKER_DEFINES_SVH
`define PREFIX_CODE_BIT_PACKER_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define PCBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define PCBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pcbp_pkg.sv
`timescale 1ns / 1ps

package pcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int NUM_SYMBOLS  = 128;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

    localparam int REQ_W  = 2;
    localparam int SYM_W  = 7;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    localparam int SYM_AW = $clog2(NUM_SYMBOLS);
    localparam int ENT_W  = LEN_W + CODE_W;

    // residual bits held between items, always fewer than one byte
    localparam int RES_W  = 3;
    localparam int BUF_W  = 39;
    localparam int EMIT_W = 32;
    localparam int NB_W   = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE  = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } req_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] lim;
        lim = LEN_W'(LEN_LIMIT);
        return (len > lim) ? lim : len;
    endfunction

    function automatic logic [CODE_W-1:0] mask_code(input logic [CODE_W-1:0] word,
                                                     input logic [LEN_W-1:0] len);
        logic [CODE_W:0] m;
        m = ((CODE_W+1)'(1) << len) - (CODE_W+1)'(1);
        return word & m[CODE_W-1:0];
    endfunction

endpackage

FILE: rtl/core/prefix_code_bit_packer.sv
`timescale 1ns / 1ps
`include "prefix_code_bit_packer_defines.svh"

// Prefix-code encoder packing code bits MSB-first into bytes. A write word stores a
// symbol's code and length in a 128-entry table memory (entries never written
// encode as nothing); an encode word appends the symbol's code and yields every full
// byte; a flush word pads with ones and yields exactly one byte with last set. A word
// is accepted every cycle as long as each encode yields at most one byte and
// out_stall is low: the table is read in the accept cycle, the bits are packed in the
// next, and the bytes leave one per cycle from a 4-byte output register; an item with
// bytes holds the input until the last earlier byte leaves. Writes take effect in
// time for an encode in the following cycle. No clearing pass is needed after reset.
module prefix_code_bit_packer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pcbp_pkg::REQ_W-1:0]    req_type,
    input  logic [pcbp_pkg::SYM_W-1:0]    symbol,
    input  logic [pcbp_pkg::CODE_W-1:0]   code_word,
    input  logic [pcbp_pkg::LEN_W-1:0]    code_length,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pcbp_pkg::BYTE_W-1:0]   out_byte,
    output logic                          last
);

    logic                              in_acc;
    logic                              in_range;
    logic                              is_wr;
    logic                              is_enc;
    logic                              is_flush;
    logic [pcbp_pkg::SYM_AW-1:0]       addr;
    logic [pcbp_pkg::LEN_W-1:0]        wr_len;
    logic [pcbp_pkg::ENT_W-1:0]        wr_ent;
    logic [pcbp_pkg::ENT_W-1:0]        rd_ent;

    logic [pcbp_pkg::NUM_SYMBOLS-1:0]  vld_reg;
    logic [pcbp_pkg::NUM_SYMBOLS-1:0]  vld_next;

    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    logic                              s1_flush_reg;
    logic                              s1_hit_reg;
    logic                              s1_fire;

    logic [pcbp_pkg::RES_W-1:0]        cnt_reg;
    logic [pcbp_pkg::RES_W-1:0]        cnt_next;
    logic [pcbp_pkg::RES_W+3:0]        buf_reg;
    logic [pcbp_pkg::RES_W+3:0]        buf_next;

    logic [pcbp_pkg::EMIT_W-1:0]       emit_reg;
    logic [pcbp_pkg::EMIT_W-1:0]       emit_next;
    logic [pcbp_pkg::NB_W-1:0]         emit_cnt_reg;
    logic [pcbp_pkg::NB_W-1:0]         emit_cnt_next;
    logic                              emit_free;
    logic                              out_acc;

    logic [pcbp_pkg::LEN_W-1:0]        ent_len;
    logic [pcbp_pkg::CODE_W-1:0]       ent_code;
    logic [pcbp_pkg::BUF_W-1:0]        full;
    logic [pcbp_pkg::BUF_W-1:0]        shifted;
    logic [pcbp_pkg::BUF_W-1:0]        aligned;
    logic [pcbp_pkg::LEN_W-1:0]        total;
    logic [pcbp_pkg::NB_W-1:0]         nbytes;
    logic [pcbp_pkg::RES_W-1:0]        rem;
    logic [pcbp_pkg::LEN_W-1:0]        lsh;
    logic [2*pcbp_pkg::BYTE_W-1:0]     pad_src;
    logic [2*pcbp_pkg::BYTE_W-1:0]     pad_shift;
    logic [pcbp_pkg::BYTE_W:0]         rem_mask;

    logic [pcbp_pkg::NB_W-1:0]         s1_nbytes;
    logic [pcbp_pkg::EMIT_W-1:0]       s1_emit;
    logic [pcbp_pkg::RES_W-1:0]        s1_cnt;
    logic [pcbp_pkg::RES_W+3:0]        s1_buf;

    assign in_acc   = in_valid && !in_stall;
    assign in_range = int'(symbol) < pcbp_pkg::NUM_SYMBOLS;
    assign addr     = pcbp_pkg::SYM_AW'(symbol);

    always_comb
    begin
        is_wr    = 1'b0;
        is_enc   = 1'b0;
        is_flush = 1'b0;
        case (req_type)
            pcbp_pkg::REQ_WRITE:  is_wr    = in_range;
            pcbp_pkg::REQ_ENCODE: is_enc   = in_range;
            pcbp_pkg::REQ_FLUSH:  is_flush = 1'b1;
            default:              ;
        endcase
    end

    assign wr_len = pcbp_pkg::sat_len(code_length);
    assign wr_ent = {wr_len, pcbp_pkg::mask_code(code_word, wr_len)};

    pcbp_ram #(
        .WIDTH (pcbp_pkg::ENT_W),
        .DEPTH (pcbp_pkg::NUM_SYMBOLS)
    ) u_table (
        .clk   (clk),
        .we    (in_acc && is_wr),
        .waddr (addr),
        .wdata (wr_ent),
        .re    (in_acc && is_enc),
        .raddr (addr),
        .rdata (rd_ent)
    );

    always_comb
    begin
        vld_next = vld_reg;
        if (in_acc && is_wr)
        begin
            vld_next[addr] = 1'b1;
        end
    end

    // Packing stage: table entry arrives here in the cycle after accept
    assign ent_len  = s1_hit_reg ? rd_ent[pcbp_pkg::ENT_W-1 -: pcbp_pkg::LEN_W]
                                 : '0;
    assign ent_code = s1_hit_reg ? rd_ent[pcbp_pkg::CODE_W-1:0] : '0;

    assign full    = (pcbp_pkg::BUF_W'(buf_reg) << ent_len)
                   | pcbp_pkg::BUF_W'(ent_code);
    assign total   = pcbp_pkg::LEN_W'(cnt_reg) + ent_len;
    assign nbytes  = total[pcbp_pkg::LEN_W-1:3];
    assign rem     = total[2:0];
    assign shifted = full >> rem;
    assign lsh     = pcbp_pkg::LEN_W'(pcbp_pkg::EMIT_W) - {nbytes, 3'b000};
    // left-align the full bytes, oldest in the top byte
    assign aligned = shifted << lsh;
    assign rem_mask = ((pcbp_pkg::BYTE_W+1)'(1) << rem) - (pcbp_pkg::BYTE_W+1)'(1);

    assign pad_src   = {1'b0, buf_reg, {pcbp_pkg::BYTE_W{1'b1}}};
    assign pad_shift = pad_src >> cnt_reg;

    always_comb
    begin
        if (s1_flush_reg)
        begin
            s1_nbytes = pcbp_pkg::NB_W'(1);
            s1_emit   = {pad_shift[pcbp_pkg::BYTE_W-1:0],
                         {(pcbp_pkg::EMIT_W-pcbp_pkg::BYTE_W){1'b0}}};
            s1_cnt    = '0;
            s1_buf    = '0;
        end
        else
        begin
            s1_nbytes = nbytes;
            s1_emit   = aligned[pcbp_pkg::EMIT_W-1:0];
            s1_cnt    = rem;
            s1_buf    = full[pcbp_pkg::RES_W+3:0] & rem_mask[pcbp_pkg::RES_W+3:0];
        end
    end

    assign out_acc   = out_valid && !out_stall;
    assign emit_free = (emit_cnt_reg == '0)
                    || (emit_cnt_reg == pcbp_pkg::NB_W'(1) && !out_stall);
    // an item yielding no bytes passes even while the output is busy
    assign s1_fire   = s1_valid_reg && (s1_nbytes == '0 || emit_free);
    assign in_stall  = s1_valid_reg && !s1_fire;

    assign s1_valid_next = in_acc ? (is_enc || is_flush) : (s1_valid_reg && !s1_fire);

    always_comb
    begin
        cnt_next = cnt_reg;
        buf_next = buf_reg;
        if (s1_fire)
        begin
            cnt_next = s1_cnt;
            buf_next = s1_buf;
        end
    end

    always_comb
    begin
        emit_next     = emit_reg;
        emit_cnt_next = emit_cnt_reg;
        if (s1_fire && s1_nbytes != '0)
        begin
            emit_next     = s1_emit;
            emit_cnt_next = s1_nbytes;
        end
        else if (out_acc)
        begin
            emit_next     = emit_reg << pcbp_pkg::BYTE_W;
            emit_cnt_next = emit_cnt_reg - pcbp_pkg::NB_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            s1_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            buf_reg      <= '0;
            emit_cnt_reg <= '0;
        end
        else
        begin
            vld_reg      <= vld_next;
            s1_valid_reg <= s1_valid_next;
            cnt_reg      <= cnt_next;
            buf_reg      <= buf_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_reg <= emit_next;
        if (in_acc)
        begin
            s1_flush_reg <= is_flush;
            s1_hit_reg   <= vld_reg[addr];
        end
    end

    assign out_valid = emit_cnt_reg != '0;
    assign out_byte  = emit_reg[pcbp_pkg::EMIT_W-1 -: pcbp_pkg::BYTE_W];
    assign last      = emit_cnt_reg == pcbp_pkg::NB_W'(1);

    `PCBP_ASSERT_NOW(a_emit_cnt_range, 1'b1, emit_cnt_reg <= pcbp_pkg::NB_W'(4),
        "output register holds more than four bytes")
    `PCBP_ASSERT_NOW(a_residual_clean, 1'b1, (buf_reg >> cnt_reg) == '0,
        "residual buffer holds bits above its count")
    `PCBP_ASSERT_NEXT(a_flush_clears, s1_fire && s1_flush_reg,
        cnt_reg == '0 && buf_reg == '0 && emit_cnt_reg == pcbp_pkg::NB_W'(1),
        "flush did not clear the buffer or load one byte")
    `PCBP_ASSERT_NEXT(a_write_marks, in_acc && is_wr, vld_reg[$past(addr)],
        "table write did not mark its entry")

endmodule

FILE: rtl/core/pcbp_ram.sv
`timescale 1ns / 1ps

module pcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/prefix_code_bit_packer_tb.sv
`timescale 1ns / 1ps

module prefix_code_bit_packer_tb;

    localparam logic [pcbp_pkg::REQ_W-1:0] REQ_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [pcbp_pkg::BYTE_W-1:0] value;
        logic                        fin;
    } packed_byte_t;

    // Tracks the code tables and the pending bit buffer, and keeps the bytes still owed
    class packed_byte_book;
        packed_byte_t                owed_bytes[$];
        logic [pcbp_pkg::CODE_W-1:0] code_mem [pcbp_pkg::NUM_SYMBOLS];
        logic [pcbp_pkg::LEN_W-1:0]  len_mem [pcbp_pkg::NUM_SYMBOLS];
        logic [63:0]                 held_bits;
        int unsigned                 held_count;
        int                          mismatches;
        int                          checked;

        function new();
            foreach (len_mem[i])
            begin
                len_mem[i] = '0;
                code_mem[i] = '0;
            end
            held_bits = '0;
            held_count = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function logic [63:0] ones(int unsigned n);
            return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        endfunction

        function void note_item(logic [pcbp_pkg::REQ_W-1:0] req,
                                logic [pcbp_pkg::SYM_W-1:0] sym,
                                logic [pcbp_pkg::CODE_W-1:0] word,
                                logic [pcbp_pkg::LEN_W-1:0] len);
            int unsigned  l;
            int unsigned  pad;
            int           produced;
            logic [63:0]  m;
            packed_byte_t e;
            produced = 0;
            case (req)
                pcbp_pkg::REQ_WRITE:
                begin
                    l = (int'(len) > pcbp_pkg::LEN_LIMIT) ? pcbp_pkg::LEN_LIMIT : int'(len);
                    m = ones(l);
                    code_mem[sym] = word & m[pcbp_pkg::CODE_W-1:0];
                    len_mem[sym] = pcbp_pkg::LEN_W'(l);
                end
                pcbp_pkg::REQ_ENCODE:
                begin
                    l = int'(len_mem[sym]);
                    if (l != 0)
                    begin
                        held_bits = (held_bits << l) | (64'(code_mem[sym]) & ones(l));
                        held_count += l;
                    end
                    // emit every full byte, oldest bits first
                    while (held_count >= 8)
                    begin
                        e.value = pcbp_pkg::BYTE_W'(held_bits >> (held_count - 8));
                        e.fin = 1'b0;
                        owed_bytes.push_back(e);
                        held_count -= 8;
                        held_bits &= ones(held_count);
                        produced++;
                    end
                    if (produced > 0)
                        owed_bytes[owed_bytes.size() - 1].fin = 1'b1;
                end
                pcbp_pkg::REQ_FLUSH:
                begin
                    pad = 8 - (held_count & 7);
                    e.value = pcbp_pkg::BYTE_W'((held_bits << pad) | ones(pad));
                    e.fin = 1'b1;
                    owed_bytes.push_back(e);
                    held_bits = '0;
                    held_count = 0;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_byte(logic [pcbp_pkg::BYTE_W-1:0] got_byte, logic got_last);
            packed_byte_t e;
            if (owed_bytes.size() == 0)
            begin
                $error("out_byte: none expected, got %02h (last %0b)", got_byte, got_last);
                mismatches++;
                return;
            end
            e = owed_bytes.pop_front();
            checked++;
            if (got_byte !== e.value)
            begin
                $error("out_byte: expected %02h, got %02h", e.value, got_byte);
                mismatches++;
            end
            if (got_last !== e.fin)
            begin
                $error("last: expected %0b, got %0b", e.fin, got_last);
                mismatches++;
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [pcbp_pkg::REQ_W-1:0]  req_type = '0;
    logic [pcbp_pkg::SYM_W-1:0]  symbol = '0;
    logic [pcbp_pkg::CODE_W-1:0] code_word = '0;
    logic [pcbp_pkg::LEN_W-1:0]  code_length = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [pcbp_pkg::BYTE_W-1:0] out_byte;
    logic                        last;

    packed_byte_book             book;
    int                          idle_pct = 0;
    int                          stall_pct = 0;
    bit                          hold_on = 1'b0;
    int                          hold_count = 0;
    int                          cycles = 0;
    int                          words_sent = 0;
    logic [pcbp_pkg::SYM_W-1:0]  known_syms[$];
    bit                          sym_known [pcbp_pkg::NUM_SYMBOLS];

    prefix_code_bit_packer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last        (last)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycles);
            $display("prefix_code_bit_packer_tb NOT OK");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off during the pressure phase
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_on && hold_count < HOLD_CYCLES)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            book.note_item(req_type, symbol, code_word, code_length);
        if (rst_n && out_valid && !out_stall)
            book.check_byte(out_byte, last);
    end

    task automatic send_word(logic [pcbp_pkg::REQ_W-1:0] req,
                             logic [pcbp_pkg::SYM_W-1:0] sym,
                             logic [pcbp_pkg::CODE_W-1:0] word,
                             logic [pcbp_pkg::LEN_W-1:0] len);
        in_valid <= 1'b1;
        req_type <= req;
        symbol <= sym;
        code_word <= word;
        code_length <= len;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        words_sent++;
        if (req == pcbp_pkg::REQ_WRITE && !sym_known[sym])
        begin
            sym_known[sym] = 1'b1;
            known_syms.push_back(sym);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (book.owed_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_items(int count);
        int                          choose;
        int                          sent;
        logic [pcbp_pkg::SYM_W-1:0]  sym;
        logic [pcbp_pkg::LEN_W-1:0]  len;
        sent = 0;
        while (sent < count)
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            choose = $urandom_range(99);
            if (choose < 20)
            begin
                // favour a small set of symbols so they get rewritten often
                sym = ($urandom_range(3) != 0) ? pcbp_pkg::SYM_W'($urandom_range(15))
                                               : pcbp_pkg::SYM_W'($urandom_range(127));
                if ($urandom_range(9) < 7)
                    len = pcbp_pkg::LEN_W'($urandom_range(10, 1));
                else if ($urandom_range(1) == 0)
                    len = pcbp_pkg::LEN_W'($urandom_range(32, 11));
                else
                    len = pcbp_pkg::LEN_W'($urandom_range(63));
                send_word(pcbp_pkg::REQ_WRITE, sym, $urandom, len);
                sent++;
            end
            else if (choose < 85)
            begin
                sym = known_syms[$urandom_range(known_syms.size() - 1)];
                send_word(pcbp_pkg::REQ_ENCODE, sym, $urandom,
                          pcbp_pkg::LEN_W'($urandom_range(63)));
                sent++;
            end
            else if (choose < 95)
            begin
                send_word(pcbp_pkg::REQ_FLUSH, pcbp_pkg::SYM_W'($urandom_range(127)),
                          $urandom, pcbp_pkg::LEN_W'($urandom_range(63)));
                sent++;
            end
            else
                send_word(REQ_NONE, pcbp_pkg::SYM_W'($urandom_range(127)),
                          $urandom, pcbp_pkg::LEN_W'($urandom_range(63)));
        end
    endtask

    initial
    begin
        book = new();
        foreach (sym_known[i])
            sym_known[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(pcbp_pkg::REQ_WRITE, 7'd0, 32'h0000_0001, 6'd1);
        send_word(pcbp_pkg::REQ_WRITE, 7'd127, 32'hDEAD_BEEF, 6'd32);
        // overlong length saturates to the limit
        send_word(pcbp_pkg::REQ_WRITE, 7'd5, 32'hFFFF_FFFF, 6'd63);
        // bits above the length are dropped
        send_word(pcbp_pkg::REQ_WRITE, 7'd6, 32'hAAAA_AAAB, 6'd3);
        send_word(pcbp_pkg::REQ_WRITE, 7'd7, 32'h1234_5678, 6'd0);
        send_word(pcbp_pkg::REQ_WRITE, 7'd8, 32'h0000_0000, 6'd33);
        send_word(pcbp_pkg::REQ_FLUSH, 7'd0, 32'h0, 6'd0);
        send_word(pcbp_pkg::REQ_ENCODE, 7'd127, 32'h0, 6'd0);
        send_word(pcbp_pkg::REQ_ENCODE, 7'd0, 32'hFFFF_FFFF, 6'd63);
        send_word(pcbp_pkg::REQ_ENCODE, 7'd7, 32'h0, 6'd0);
        send_word(pcbp_pkg::REQ_ENCODE, 7'd5, 32'h0, 6'd0);
        send_word(REQ_NONE, 7'd127, 32'hFFFF_FFFF, 6'd63);
        send_word(pcbp_pkg::REQ_ENCODE, 7'd6, 32'h0, 6'd0);
        send_word(pcbp_pkg::REQ_FLUSH, 7'd127, 32'hFFFF_FFFF, 6'd63);
        send_word(pcbp_pkg::REQ_ENCODE, 7'd8, 32'h0, 6'd0);
        send_word(pcbp_pkg::REQ_FLUSH, 7'd0, 32'h0, 6'd0);
        // seven pending bits before the flush
        send_word(pcbp_pkg::REQ_ENCODE, 7'd6, 32'h0, 6'd0);
        send_word(pcbp_pkg::REQ_ENCODE, 7'd6, 32'h0, 6'd0);
        send_word(pcbp_pkg::REQ_ENCODE, 7'd0, 32'h0, 6'd0);
        send_word(pcbp_pkg::REQ_FLUSH, 7'd0, 32'h0, 6'd0);
        send_word(pcbp_pkg::REQ_WRITE, 7'd127, 32'h0000_0000, 6'd0);
        send_word(pcbp_pkg::REQ_ENCODE, 7'd127, 32'h0, 6'd0);
        wait_drain();

        idle_pct = 0;
        stall_pct = 0;
        random_items(25);
        idle_pct = 49;
        random_items(25);
        idle_pct = 0;
        stall_pct = 49;
        random_items(25);
        idle_pct = 17;
        stall_pct = 17;
        random_items(25);
        wait_drain();

        // hold the output off while words keep coming, so the input backs up
        idle_pct = 0;
        stall_pct = 0;
        hold_on = 1'b1;
        random_items(25);
        wait_drain();
        hold_on = 1'b0;

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d words accepted, %0d bytes checked in %0d cycles",
                 words_sent, book.checked, cycles);
        $display("covered: table writes, encodes, flushes, ignored requests; ",
                 "idle, stall and hold-off mixes");
        if (book.mismatches == 0 && book.owed_bytes.size() == 0)
            $display("prefix_code_bit_packer_tb OK");
        else
            $display("prefix_code_bit_packer_tb NOT OK");
        $finish;
    end

endmodule

FILE: prefix_code_bit_packer.f
+incdir+rtl/core
rtl/core/pcbp_pkg.sv
rtl/core/pcbp_ram.sv
rtl/core/prefix_code_bit_packer.sv
tb/prefix_code_bit_packer_tb.sv
